/* src/abpll_pkg.sv */
// Shared types and constants for the alpha/beta PLL.
// Holds the microcode word layout, the step enum and the fixed field widths.
// No dependencies.
package abpll_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ITER_W       = $clog2(CORDIC_STEPS);
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_STEPS - 1);

    localparam int GAIN_W     = 32;
    localparam int FREQ_W     = 32;
    localparam int ERR_OUT_W  = 34;
    localparam int FILT_SHIFT = 30;
    localparam int ANGLE_W    = 32;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_B0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_B1 = 2'd1;

    typedef enum logic [3:0] {
        ST_WAIT_IN,
        ST_MUL_BETA,
        ST_MUL_ALPHA,
        ST_SUM_RAW,
        ST_SCALE_ERR,
        ST_MUL_B0,
        ST_MUL_B1,
        ST_SUM_FILT,
        ST_FREQ,
        ST_PHASE,
        ST_ROT_INIT,
        ST_ROT_STEP,
        ST_TRIG,
        ST_OUT
    } step_t;

    typedef enum logic [1:0] {MA_BETA, MA_ALPHA, MA_ERR, MA_ERR_PREV} mul_a_t;
    typedef enum logic [1:0] {MB_SINE, MB_COSINE, MB_GAIN_B0, MB_GAIN_B1} mul_b_t;
    typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_op_t;
    typedef enum logic [1:0] {JC_NEXT, JC_WAIT_IN, JC_LOOP, JC_WAIT_OUT} jump_t;

    typedef struct packed {
        mul_a_t  mul_a;
        mul_b_t  mul_b;
        acc_op_t acc_op;
        logic    wr_err;
        logic    wr_freq;
        logic    wr_phase;
        logic    rot_init;
        logic    rot_step;
        logic    wr_trig;
        logic    take_in;
        logic    give_out;
        jump_t   jump;
        step_t   target;
    } ucode_t;

    typedef struct packed {
        ucode_t              uc;
        logic [ITER_W-1:0]   iter;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic out_free;
    } seq_status_t;

endpackage

/* src/abpll_seq.sv */
// Microcode sequencer for the alpha/beta PLL: step counter, control ROM,
// loop counter for the rotation steps and conditional jumps.
// Depends on abpll_pkg.
module abpll_seq (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  abpll_pkg::seq_status_t    status,
    output abpll_pkg::ctrl_t          ctrl
);
    import abpll_pkg::*;

    step_t             step_reg;
    step_t             step_next;
    logic [ITER_W-1:0] iter_reg;
    logic [ITER_W-1:0] iter_next;
    ucode_t            word;

    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        w        = '0;
        w.mul_a  = MA_BETA;
        w.mul_b  = MB_SINE;
        w.acc_op = ACC_HOLD;
        w.jump   = JC_NEXT;
        w.target = ST_WAIT_IN;
        case (step)
            ST_WAIT_IN: begin
                w.take_in = 1'b1;
                w.jump    = JC_WAIT_IN;
            end
            ST_MUL_BETA: begin
                w.mul_a = MA_BETA;
                w.mul_b = MB_SINE;
            end
            ST_MUL_ALPHA: begin
                w.mul_a  = MA_ALPHA;
                w.mul_b  = MB_COSINE;
                w.acc_op = ACC_LOAD;
            end
            ST_SUM_RAW:   w.acc_op = ACC_ADD;
            ST_SCALE_ERR: w.wr_err = 1'b1;
            ST_MUL_B0: begin
                w.mul_a = MA_ERR;
                w.mul_b = MB_GAIN_B0;
            end
            ST_MUL_B1: begin
                w.mul_a  = MA_ERR_PREV;
                w.mul_b  = MB_GAIN_B1;
                w.acc_op = ACC_LOAD;
            end
            ST_SUM_FILT:  w.acc_op = ACC_ADD;
            ST_FREQ:      w.wr_freq = 1'b1;
            ST_PHASE:     w.wr_phase = 1'b1;
            ST_ROT_INIT:  w.rot_init = 1'b1;
            ST_ROT_STEP: begin
                w.rot_step = 1'b1;
                w.jump     = JC_LOOP;
                w.target   = ST_ROT_STEP;
            end
            ST_TRIG:      w.wr_trig = 1'b1;
            ST_OUT: begin
                w.give_out = 1'b1;
                w.jump     = JC_WAIT_OUT;
                w.target   = ST_WAIT_IN;
            end
            default: begin
                w.jump   = JC_WAIT_OUT;
                w.target = ST_WAIT_IN;
            end
        endcase
        return w;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= ST_WAIT_IN;
            iter_reg <= '0;
        end else begin
            step_reg <= step_next;
            iter_reg <= iter_next;
        end
    end

    always_comb begin
        word      = ucode_rom(step_reg);
        step_next = step_reg;
        iter_next = iter_reg;
        case (word.jump)
            JC_NEXT: step_next = step_t'(step_reg + 4'd1);
            JC_WAIT_IN: begin
                if (status.in_valid) begin
                    step_next = step_t'(step_reg + 4'd1);
                end
            end
            JC_LOOP: begin
                // repeat the step until the last rotation is done
                if (iter_reg == ITER_LAST) begin
                    step_next = step_t'(step_reg + 4'd1);
                    iter_next = '0;
                end else begin
                    step_next = word.target;
                    iter_next = iter_reg + 1'b1;
                end
            end
            JC_WAIT_OUT: begin
                if (status.out_free) begin
                    step_next = word.target;
                end
            end
            default: step_next = ST_WAIT_IN;
        endcase
        ctrl.uc   = word;
        ctrl.iter = iter_reg;
    end

endmodule

/* src/abpll_cordic.sv */
// Iterative rotation-mode CORDIC in turns: one micro-rotation per cycle,
// quadrant folding and rounding to sample width. Depends on abpll_pkg.
module abpll_cordic #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                              aclk,
    input  abpll_pkg::ctrl_t                  ctrl,
    input  logic [abpll_pkg::ANGLE_W-1:0]     angle,
    output logic signed [SAMPLE_BITS-1:0]     sine,
    output logic signed [SAMPLE_BITS-1:0]     cosine
);
    import abpll_pkg::*;

    localparam int ROT_W  = ANGLE_W;
    localparam int RND_SH = 31 - SAMPLE_BITS;
    localparam logic [ROT_W:0] RND_HALF = {{ROT_W{1'b0}}, 1'b1} << (RND_SH - 1);
    localparam logic signed [ROT_W-1:0] GAIN_INIT = 32'sd652032874;
    localparam logic [ANGLE_W-1:0] EIGHTH_TURN = 32'h2000_0000;

    logic signed [ROT_W-1:0] x_reg, y_reg, z_reg;
    logic [1:0]              quad_reg;
    logic [ANGLE_W-1:0]      shifted;
    logic [1:0]              quad_next;
    logic signed [ROT_W-1:0] dx, dy;
    logic signed [ROT_W-1:0] sin_full, cos_full;

    function automatic logic signed [ROT_W-1:0] atan_turns(input logic [ITER_W-1:0] i);
        logic signed [ROT_W-1:0] a;
        case (i)
            4'd0:  a = 32'sd536870912;
            4'd1:  a = 32'sd316933406;
            4'd2:  a = 32'sd167458907;
            4'd3:  a = 32'sd85004756;
            4'd4:  a = 32'sd42667331;
            4'd5:  a = 32'sd21354465;
            4'd6:  a = 32'sd10679838;
            4'd7:  a = 32'sd5340245;
            4'd8:  a = 32'sd2670163;
            4'd9:  a = 32'sd1335087;
            4'd10: a = 32'sd667544;
            4'd11: a = 32'sd333772;
            4'd12: a = 32'sd166886;
            4'd13: a = 32'sd83443;
            4'd14: a = 32'sd41721;
            4'd15: a = 32'sd20861;
            default: a = '0;
        endcase
        return a;
    endfunction

    // round half up to sample fraction bits, then saturate
    function automatic logic signed [SAMPLE_BITS-1:0] to_sample(
        input logic signed [ROT_W-1:0] v
    );
        logic signed [ROT_W:0] vr;
        logic signed [ROT_W:0] r;
        logic                  fits;
        logic signed [SAMPLE_BITS-1:0] s;
        vr   = $signed({v[ROT_W-1], v} + RND_HALF);
        r    = vr >>> RND_SH;
        fits = (&r[ROT_W:SAMPLE_BITS-1]) || !(|r[ROT_W:SAMPLE_BITS-1]);
        if (fits) begin
            s = r[SAMPLE_BITS-1:0];
        end else if (r[ROT_W]) begin
            s = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            s = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
        return s;
    endfunction

    assign shifted   = angle + EIGHTH_TURN;
    assign quad_next = shifted[ANGLE_W-1:ANGLE_W-2];
    assign dx        = y_reg >>> ctrl.iter;
    assign dy        = x_reg >>> ctrl.iter;

    always_ff @(posedge aclk) begin
        if (ctrl.uc.rot_init) begin
            x_reg    <= GAIN_INIT;
            y_reg    <= '0;
            z_reg    <= $signed(angle - {quad_next, {(ANGLE_W-2){1'b0}}});
            quad_reg <= quad_next;
        end else if (ctrl.uc.rot_step) begin
            if (!z_reg[ROT_W-1]) begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - atan_turns(ctrl.iter);
            end else begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + atan_turns(ctrl.iter);
            end
        end
    end

    always_comb begin
        case (quad_reg)
            2'd0: begin
                sin_full = y_reg;
                cos_full = x_reg;
            end
            2'd1: begin
                sin_full = x_reg;
                cos_full = -y_reg;
            end
            2'd2: begin
                sin_full = -y_reg;
                cos_full = -x_reg;
            end
            default: begin
                sin_full = -x_reg;
                cos_full = y_reg;
            end
        endcase
        sine   = to_sample(sin_full);
        cosine = to_sample(cos_full);
    end

endmodule

/* src/alpha_beta_pll_top.sv */
// Alpha/beta frame PLL with PI loop filter: shared multiplier datapath run by
// a microcode sequencer, plus iterative CORDIC. Depends on abpll_pkg,
// abpll_seq and abpll_cordic.
//
//   channel  | handshake           | payload
//   ---------+---------------------+-----------------------------------------
//   s_       | s_valid / s_ready   | sample_alpha, sample_beta
//   m_       | m_valid / m_ready   | phase_angle, sine_out, cosine_out,
//            |                     | freq_word, phase_error
//   cfg_     | cfg_wr_en           | cfg_wr_index, cfg_wr_data
//
// One item at a time: accept, detector and filter steps, the CORDIC rotation
// loop, then the result; four products share one registered multiplier.
// A new item is taken once the previous result has moved into the output
// register, so no new sample is accepted while one is still in flight.
// A stalled output holds the sequencer in its last step; no item is lost.
// Reset (aresetn low, synchronous) clears loop state, gains and handshakes.
module alpha_beta_pll_top #(
    parameter int PHASE_BITS  = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [abpll_pkg::CFG_IDX_W-1:0]       cfg_wr_index,
    input  logic [abpll_pkg::GAIN_W-1:0]          cfg_wr_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [SAMPLE_BITS-1:0]         s_sample_alpha,
    input  logic signed [SAMPLE_BITS-1:0]         s_sample_beta,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [PHASE_BITS-1:0]                 m_phase_angle,
    output logic signed [SAMPLE_BITS-1:0]         m_sine_out,
    output logic signed [SAMPLE_BITS-1:0]         m_cosine_out,
    output logic signed [abpll_pkg::FREQ_W-1:0]   m_freq_word,
    output logic signed [abpll_pkg::ERR_OUT_W-1:0] m_phase_error
);
    import abpll_pkg::*;

    // cosine history keeps room for its reset value at narrow sample widths
    localparam int TRIG_W  = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
    localparam int FRAC    = 2 * (SAMPLE_BITS - 1);
    localparam int SH_DN   = (FRAC >= 30) ? FRAC - 30 : 0;
    localparam int SH_UP   = (FRAC < 30) ? 30 - FRAC : 0;
    localparam int RAW_W   = SAMPLE_BITS + TRIG_W + 1;
    localparam int ERR_FIT = RAW_W - SH_DN + SH_UP;
    localparam int ERR_W   = (ERR_FIT > ERR_OUT_W) ? ERR_FIT : ERR_OUT_W;
    localparam int PROD_W  = ERR_W + GAIN_W;
    localparam int ACC_W   = PROD_W + 1;
    localparam int DELTA_W = ACC_W - FILT_SHIFT;
    localparam int FSUM_W  = DELTA_W + 1;
    localparam int PEXT_W  = PHASE_BITS + FREQ_W;
    localparam int ANG_DN  = (PHASE_BITS > ANGLE_W) ? PHASE_BITS - ANGLE_W : 0;
    localparam int ANG_UP  = (PHASE_BITS < ANGLE_W) ? ANGLE_W - PHASE_BITS : 0;
    localparam logic signed [TRIG_W-1:0] COS_RESET = TRIG_W'(32767);

    ctrl_t       ctrl;
    seq_status_t status;

    logic signed [GAIN_W-1:0]      gain_b0_reg, gain_b1_reg;
    logic signed [SAMPLE_BITS-1:0] alpha_reg, beta_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [ACC_W-1:0]       acc_reg, acc_next;
    logic signed [ERR_W-1:0]       err_reg, error_prev_reg;
    logic signed [FREQ_W-1:0]      freq_now_reg, freq_now_next, freq_prev_reg;
    logic [PHASE_BITS-1:0]         phase_acc_reg, phase_acc_next;
    logic signed [SAMPLE_BITS-1:0] sine_prev_reg;
    logic signed [TRIG_W-1:0]      cosine_prev_reg;

    logic signed [ERR_W-1:0]       mul_a;
    logic signed [GAIN_W-1:0]      mul_b;
    logic signed [ACC_W-1:0]       prod_ext;
    logic signed [ACC_W-1:0]       err_shift;
    logic signed [DELTA_W-1:0]     delta;
    logic signed [FSUM_W-1:0]      fsum;
    logic                          fsum_fits;
    logic [PEXT_W-1:0]             phase_sum;
    logic [PHASE_BITS+ANGLE_W-1:0] ang_wide;
    logic [ANGLE_W-1:0]            rot_angle;
    logic signed [SAMPLE_BITS-1:0] rot_sine, rot_cosine;

    logic                          out_free, out_load, m_valid_reg, m_valid_next;
    logic [PHASE_BITS-1:0]         out_phase_reg;
    logic signed [SAMPLE_BITS-1:0] out_sine_reg, out_cosine_reg;
    logic signed [FREQ_W-1:0]      out_freq_reg;
    logic signed [ERR_OUT_W-1:0]   out_err_reg;

    assign status.in_valid = s_valid;
    assign status.out_free = out_free;

    abpll_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    abpll_cordic #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cordic (
        .aclk   (aclk),
        .ctrl   (ctrl),
        .angle  (rot_angle),
        .sine   (rot_sine),
        .cosine (rot_cosine)
    );

    // shared multiplier operands
    always_comb begin
        case (ctrl.uc.mul_a)
            MA_BETA:     mul_a = {{(ERR_W-SAMPLE_BITS){beta_reg[SAMPLE_BITS-1]}}, beta_reg};
            MA_ALPHA:    mul_a = {{(ERR_W-SAMPLE_BITS){alpha_reg[SAMPLE_BITS-1]}}, alpha_reg};
            MA_ERR:      mul_a = err_reg;
            MA_ERR_PREV: mul_a = error_prev_reg;
            default:     mul_a = '0;
        endcase
        case (ctrl.uc.mul_b)
            MB_SINE:
                mul_b = {{(GAIN_W-SAMPLE_BITS){sine_prev_reg[SAMPLE_BITS-1]}}, sine_prev_reg};
            MB_COSINE:
                mul_b = {{(GAIN_W-TRIG_W){cosine_prev_reg[TRIG_W-1]}}, cosine_prev_reg};
            MB_GAIN_B0: mul_b = gain_b0_reg;
            MB_GAIN_B1: mul_b = gain_b1_reg;
            default:    mul_b = '0;
        endcase
    end

    assign prod_ext = {prod_reg[PROD_W-1], prod_reg};

    always_comb begin
        case (ctrl.uc.acc_op)
            ACC_LOAD: acc_next = prod_ext;
            ACC_ADD:  acc_next = acc_reg + prod_ext;
            default:  acc_next = acc_reg;
        endcase
    end

    // bring the detector sum to 30 fraction bits; floor on a right shift
    assign err_shift = (acc_reg >>> SH_DN) <<< SH_UP;

    // PI update: floor of the gain sum over 2^30, then saturate
    assign delta     = acc_reg[ACC_W-1:FILT_SHIFT];
    assign fsum      = {{(FSUM_W-FREQ_W){freq_now_reg[FREQ_W-1]}}, freq_now_reg}
                     + {delta[DELTA_W-1], delta};
    assign fsum_fits = (&fsum[FSUM_W-1:FREQ_W-1]) || !(|fsum[FSUM_W-1:FREQ_W-1]);

    always_comb begin
        if (fsum_fits) begin
            freq_now_next = fsum[FREQ_W-1:0];
        end else if (fsum[FSUM_W-1]) begin
            freq_now_next = {1'b1, {(FREQ_W-1){1'b0}}};
        end else begin
            freq_now_next = {1'b0, {(FREQ_W-1){1'b1}}};
        end
    end

    // trapezoidal phase advance, wraps modulo one turn
    assign phase_sum = {{FREQ_W{1'b0}}, phase_acc_reg}
                     + {{PHASE_BITS{freq_now_reg[FREQ_W-1]}}, freq_now_reg}
                     + {{PHASE_BITS{freq_prev_reg[FREQ_W-1]}}, freq_prev_reg};
    assign phase_acc_next = phase_sum[PHASE_BITS-1:0];

    assign ang_wide  = ({{ANGLE_W{1'b0}}, phase_acc_reg} >> ANG_DN) << ANG_UP;
    assign rot_angle = ang_wide[ANGLE_W-1:0];

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            alpha_reg <= s_sample_alpha;
            beta_reg  <= s_sample_beta;
        end
        prod_reg <= mul_a * mul_b;
        acc_reg  <= acc_next;
        if (ctrl.uc.wr_err) begin
            err_reg <= err_shift[ERR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_b0_reg     <= '0;
            gain_b1_reg     <= '0;
            error_prev_reg  <= '0;
            freq_now_reg    <= '0;
            freq_prev_reg   <= '0;
            phase_acc_reg   <= '0;
            sine_prev_reg   <= '0;
            cosine_prev_reg <= COS_RESET;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    CFG_GAIN_B0: gain_b0_reg <= cfg_wr_data;
                    CFG_GAIN_B1: gain_b1_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
            if (ctrl.uc.wr_freq) begin
                freq_now_reg   <= freq_now_next;
                error_prev_reg <= err_reg;
            end
            if (ctrl.uc.wr_phase) begin
                phase_acc_reg <= phase_acc_next;
                freq_prev_reg <= freq_now_reg;
            end
            if (ctrl.uc.wr_trig) begin
                sine_prev_reg   <= rot_sine;
                cosine_prev_reg <= {{(TRIG_W-SAMPLE_BITS){rot_cosine[SAMPLE_BITS-1]}},
                                    rot_cosine};
            end
        end
    end

    // output register: load when empty or being drained
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = ctrl.uc.give_out && out_free;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_phase_reg  <= phase_acc_reg;
            out_sine_reg   <= sine_prev_reg;
            out_cosine_reg <= cosine_prev_reg[SAMPLE_BITS-1:0];
            out_freq_reg   <= freq_now_reg;
            out_err_reg    <= err_reg[ERR_OUT_W-1:0];
        end
    end

    assign s_ready       = ctrl.uc.take_in;
    assign m_valid       = m_valid_reg;
    assign m_phase_angle = out_phase_reg;
    assign m_sine_out    = out_sine_reg;
    assign m_cosine_out  = out_cosine_reg;
    assign m_freq_word   = out_freq_reg;
    assign m_phase_error = out_err_reg;

    a_one_item_in_flight: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready
    ) else $error("input taken while an item is still in flight");

    a_iter_only_in_rotation: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (ctrl.iter != '0) |-> ctrl.uc.rot_step
    ) else $error("rotation counter busy outside the rotation step");

    a_rotation_starts_clean: assert property (
        @(posedge aclk) disable iff (!aresetn)
        ctrl.uc.rot_init |=> (ctrl.uc.rot_step && (ctrl.iter == '0))
    ) else $error("rotation loop did not start at step zero");

endmodule
